// ===== rtl/core/wbpm_pkg.sv =====
// Shared types, constants and helpers for the wildcard byte pattern matcher.
// No dependencies; the cell and matcher files refer to it by scoped names.
package wbpm_pkg;

   localparam int PATTERN_MAX_DEFAULT   = 16;
   localparam int ADDRESS_WIDTH_DEFAULT = 64;

   // pattern registers hold this many bytes, whatever the window depth
   localparam int REG_BYTES       = 16;
   localparam int LEN_WIDTH       = 5;
   localparam int CARE_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [CARE_WIDTH-1:0] CARE_RESET   = 16'hFFFF;
   localparam logic [LEN_WIDTH-1:0]  LENGTH_RESET = 5'd1;

   typedef logic [LEN_WIDTH-1:0]         len_type;
   typedef logic [3:0]                   pidx_type;
   typedef logic [REG_BYTES-1:0][7:0]    pattern_type;
   typedef logic [CARE_WIDTH-1:0]        care_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_CARE_MASK      = 3'd2,
      CSR_PATTERN_LENGTH = 3'd3
   } csr_type;

   // one window entry as it moves from cell to cell
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
   } link_type;

   function automatic logic byte_ok(input logic [7:0] b, input logic [7:0] p,
                                    input logic care);
      return !care || (b == p);
   endfunction

endpackage

// ===== rtl/core/wbpm_cell.sv =====
// One window cell: holds a previous byte of the region and its valid bit,
// and checks it against the pattern byte that lines up with it.
// Depends on wbpm_pkg.
module wbpm_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift,
   input  logic                  clear,
   input  wbpm_pkg::link_type    link_in,
   input  wbpm_pkg::pattern_type pattern_bytes,
   input  wbpm_pkg::care_type    care_mask,
   input  wbpm_pkg::len_type     pattern_length,
   output wbpm_pkg::link_type    link_out,
   output logic                  match_ok
);

   wbpm_pkg::link_type link_ff;
   wbpm_pkg::link_type link_in_next;
   wbpm_pkg::len_type  offset;
   wbpm_pkg::pidx_type pidx;
   logic               in_use;
   logic               valid_now;

   // a region start empties the window before the current byte is checked
   assign valid_now = link_ff.valid && !clear;
   assign link_out  = '{data: link_ff.data, valid: valid_now};

   // this cell pairs with pattern byte length-2-INDEX
   assign in_use = pattern_length > wbpm_pkg::len_type'(INDEX + 1);
   assign offset = pattern_length - wbpm_pkg::len_type'(INDEX + 2);
   assign pidx   = offset[3:0];

   always_comb begin
      if (in_use) begin
         match_ok = valid_now &&
                    wbpm_pkg::byte_ok(link_ff.data, pattern_bytes[pidx], care_mask[pidx]);
      end else begin
         match_ok = 1'b1;
      end
   end

   always_comb begin
      link_in_next = link_ff;
      if (shift) begin
         link_in_next = link_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_in_next.valid;
      end
      link_ff.data <= link_in_next.data;
   end

endmodule

// ===== rtl/core/wbpm_out_buf.sv =====
// Two-slot result buffer (output register plus skid) between the match
// logic and the response channel. No dependencies.
module wbpm_out_buf #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] out_data_ff, out_data_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;
   logic             advance;

   assign advance   = !out_valid_ff || out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (advance) begin
         // drain the skid first, it holds the older transaction
         out_valid_in  = skid_valid_ff || in_valid;
         out_data_in   = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot full while output slot empty");

endmodule

// ===== rtl/core/wildcard_byte_pattern_matcher.sv =====
// Wildcard byte pattern matcher: one byte per cycle while req_tready is high; the result
// is registered. Throughput is one transaction per cycle while req_tready is high; the
// window shifts one cell and all cells compare in parallel in the same cycle. req_tready
// drops only while both result slots are full. Synchronous reset empties the window,
// clears the found flag and result slots, and loads care_mask 0xFFFF, pattern_length 1
// and a zero pattern. Depends on wbpm_pkg, wbpm_cell and wbpm_out_buf.
module wildcard_byte_pattern_matcher #(
   parameter int PATTERN_MAX   = wbpm_pkg::PATTERN_MAX_DEFAULT,
   parameter int ADDRESS_WIDTH = wbpm_pkg::ADDRESS_WIDTH_DEFAULT,
   localparam int REQ_DATA_WIDTH = ((8 + ADDRESS_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_WIDTH = ((ADDRESS_WIDTH + 2 + 7) / 8) * 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // data_byte, byte_address, zero pad
   input  logic [REQ_DATA_WIDTH-1:0]              req_tdata,
   // region_start, new_scan
   input  logic [1:0]                             req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // match, match_address, found, zero pad
   output logic [RSP_DATA_WIDTH-1:0]              rsp_tdata,
   input  logic                                   csr_we,
   input  logic [wbpm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [wbpm_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int LEN_LIMIT  = (PATTERN_MAX < wbpm_pkg::REG_BYTES) ?
                               PATTERN_MAX : wbpm_pkg::REG_BYTES;
   // bytes deeper than the longest usable pattern never take part in a compare
   localparam int CELL_COUNT = LEN_LIMIT - 1;

   logic [63:0]        pattern_low_ff, pattern_low_in;
   logic [63:0]        pattern_high_ff, pattern_high_in;
   wbpm_pkg::care_type care_mask_ff, care_mask_in;
   wbpm_pkg::len_type  pattern_length_ff, pattern_length_in;
   logic               found_ff, found_in;

   wbpm_pkg::pattern_type    pattern_bytes;
   wbpm_pkg::len_type        len_eff;
   wbpm_pkg::len_type        len_m1;
   wbpm_pkg::pidx_type       cur_idx;
   logic [7:0]               cur_byte;
   logic [ADDRESS_WIDTH-1:0] cur_addr;
   logic                     region_start;
   logic                     new_scan;
   logic                     accept;
   logic                     cur_ok;
   logic                     hit;
   logic                     found_kept;
   logic                     report;
   logic [ADDRESS_WIDTH-1:0] match_addr;
   logic [RSP_DATA_WIDTH-1:0] rsp_data;
   logic [CELL_COUNT-1:0]    cell_ok;
   wbpm_pkg::link_type       link [0:CELL_COUNT];

   // configuration registers
   always_comb begin
      pattern_low_in    = pattern_low_ff;
      pattern_high_in   = pattern_high_ff;
      care_mask_in      = care_mask_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_we) begin
         unique case (csr_index)
            wbpm_pkg::CSR_PATTERN_LOW:    pattern_low_in    = csr_wdata;
            wbpm_pkg::CSR_PATTERN_HIGH:   pattern_high_in   = csr_wdata;
            wbpm_pkg::CSR_CARE_MASK:      care_mask_in      = csr_wdata[wbpm_pkg::CARE_WIDTH-1:0];
            wbpm_pkg::CSR_PATTERN_LENGTH: pattern_length_in = csr_wdata[wbpm_pkg::LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign pattern_bytes = {pattern_high_ff, pattern_low_ff};

   // zero means one byte; clamp to what the registers and window can hold
   always_comb begin
      priority if (pattern_length_ff == '0) begin
         len_eff = wbpm_pkg::len_type'(1);
      end else if (pattern_length_ff > wbpm_pkg::len_type'(LEN_LIMIT)) begin
         len_eff = wbpm_pkg::len_type'(LEN_LIMIT);
      end else begin
         len_eff = pattern_length_ff;
      end
   end

   assign cur_byte     = req_tdata[7:0];
   assign cur_addr     = req_tdata[8 +: ADDRESS_WIDTH];
   assign region_start = req_tuser[0];
   assign new_scan     = req_tuser[1];
   assign accept       = req_tvalid && req_tready;

   // the current byte lines up with the last pattern byte
   assign len_m1  = len_eff - wbpm_pkg::len_type'(1);
   assign cur_idx = len_m1[3:0];
   assign cur_ok  = wbpm_pkg::byte_ok(cur_byte, pattern_bytes[cur_idx], care_mask_ff[cur_idx]);

   assign link[0] = '{data: cur_byte, valid: 1'b1};

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      wbpm_cell #(
         .INDEX(i)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .shift          (accept),
         .clear          (region_start),
         .link_in        (link[i]),
         .pattern_bytes  (pattern_bytes),
         .care_mask      (care_mask_ff),
         .pattern_length (len_eff),
         .link_out       (link[i+1]),
         .match_ok       (cell_ok[i])
      );
   end

   assign hit        = cur_ok && (&cell_ok);
   assign found_kept = found_ff && !new_scan;
   assign report     = hit && !found_kept;
   assign match_addr = report ?
                       (cur_addr - ADDRESS_WIDTH'(len_eff) + ADDRESS_WIDTH'(1)) : '0;

   always_comb begin
      found_in = found_ff;
      if (accept) begin
         found_in = found_kept || report;
      end
   end

   assign rsp_data = RSP_DATA_WIDTH'({found_in, match_addr, report});

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= wbpm_pkg::CARE_RESET;
         pattern_length_ff <= wbpm_pkg::LENGTH_RESET;
         found_ff          <= 1'b0;
      end else begin
         pattern_low_ff    <= pattern_low_in;
         pattern_high_ff   <= pattern_high_in;
         care_mask_ff      <= care_mask_in;
         pattern_length_ff <= pattern_length_in;
         found_ff          <= found_in;
      end
   end

   wbpm_out_buf #(
      .WIDTH(RSP_DATA_WIDTH)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (req_tready),
      .in_data   (rsp_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   a_match_sets_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[ADDRESS_WIDTH+1])
      else $error("match reported without found flag");

   a_no_match_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> (rsp_tdata[ADDRESS_WIDTH:1] == '0))
      else $error("match address nonzero without a match");

   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      accept && found_ff && !new_scan |=> found_ff)
      else $error("found flag dropped without a new scan");

   a_window_fill_order: assert property (@(posedge clock) disable iff (reset)
      link[CELL_COUNT].valid |-> link[CELL_COUNT-1].valid)
      else $error("window holds a gap in its valid entries");

endmodule
